// ----- sv/shallow_cell_neighbor_smoothing_macros.svh -----
// Assertion macros for the smoothing block's RTL, used by the back end.
`ifndef SHALLOW_CELL_NEIGHBOR_SMOOTHING_MACROS_SVH
`define SHALLOW_CELL_NEIGHBOR_SMOOTHING_MACROS_SVH
`ifndef SYNTH
// Checks an expression at every clock edge outside reset.
`define SCNS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Checks that a condition is followed by a consequence in the next cycle.
`define SCNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SCNS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define SCNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/scns_pkg.sv -----
// Package with the types, constants and helper functions of the smoothing block.
`default_nettype none
package scns_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int STORE_DEPTH = 2 * MAX_WIDTH + 1;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int KW          = $clog2(STORE_DEPTH + 1);
  localparam int W_W         = $clog2(MAX_WIDTH + 1);
  localparam int PEND_W      = $clog2(MAX_WIDTH + 2);
  localparam logic signed [39:0] HUNDREDTH_Q16 = 40'sd655;

  localparam logic [2:0] REG_GROUND = 3'd0;
  localparam logic [2:0] REG_RATIO  = 3'd1;
  localparam logic [2:0] REG_BLEND  = 3'd2;
  localparam logic [2:0] REG_PERIOD = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  typedef struct packed {
    logic signed [31:0] ground;
    logic [20:0]        rb;
    logic [16:0]        bc;
    logic [15:0]        period;
    logic [W_W-1:0]     w_eff;
    logic [15:0]        h_eff;
  } cfg_t;

  typedef struct packed {
    logic                          emit;
    logic                          write;
    logic                          smooth_ok;
    logic                          last;
    logic [SLOT_W-1:0]             wslot;
    logic [SLOT_W-1:0]             cslot;
    logic [3:0][SLOT_W-1:0]        nb;
    logic signed [31:0]            e;
    logic signed [31:0]            u;
    logic signed [31:0]            v;
    logic signed [31:0]            d;
  } cmd_t;

  // Slot that lies k cells behind the write slot in the circular store.
  function automatic logic [SLOT_W-1:0] back_slot(input logic [SLOT_W-1:0] wr,
                                                   input logic [KW-1:0] k);
    logic [KW-1:0]   kk;
    logic [SLOT_W:0] s;
    kk = (32'(k) >= STORE_DEPTH) ? k - KW'(STORE_DEPTH) : k;
    s  = {1'b0, wr} + (SLOT_W + 1)'(STORE_DEPTH) - (SLOT_W + 1)'(kk);
    if (32'(s) >= STORE_DEPTH) begin
      s = s - (SLOT_W + 1)'(STORE_DEPTH);
    end
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic is_wet(input logic signed [31:0] e,
                                  input logic signed [31:0] d,
                                  input logic signed [31:0] gl);
    logic signed [32:0] tot;
    tot = {e[31], e} + {d[31], d};
    return (d >= gl) && (tot > 33'sd0);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/scns_front.sv -----
// Front end: accepts cells, tracks grid position and issues line store commands.
`default_nettype none
module scns_front import scns_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               per_wr,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [31:0]        in_frame_step,
  input  logic signed [31:0] in_elevation,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_depth,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t           state_r, state_nxt;
  logic [W_W-1:0]    col_r, col_nxt, ecol_r, ecol_nxt;
  logic [15:0]       row_r, row_nxt, erow_r, erow_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [SLOT_W-1:0] wr_r, wr_nxt;
  logic [31:0]       step_r, step_nxt;
  logic              mod_ok_r, mod_ok_nxt;
  logic [31:0]       dvd_r, dvd_nxt;
  logic [16:0]       rem_r, rem_nxt;
  logic [4:0]        dcnt_r, dcnt_nxt;
  logic              push_pend_r, push_pend_nxt;
  cmd_t              cmd_r, cmd_nxt;

  logic [15:0]       per_eff;
  logic [16:0]       div_sh, rem_step;
  logic              emit_full, interior, last;
  logic [31:0]       ec1, er1, c1, r1;
  logic [KW-1:0]     kp, kw;

  assign per_eff  = (cfg.period == 16'd0) ? 16'd1 : cfg.period;
  assign div_sh   = {rem_r[15:0], dvd_r[31]};
  assign rem_step = (div_sh >= {1'b0, per_eff}) ? div_sh - {1'b0, per_eff} : div_sh;

  assign emit_full = 32'(pend_r) >= 32'(cfg.w_eff) + 32'd1;
  assign interior  = (ecol_r != '0) && (32'(ecol_r) <= 32'(cfg.w_eff) - 32'd2) &&
                     (erow_r != '0) && (32'(erow_r) <= 32'(cfg.h_eff) - 32'd2);
  assign last      = (32'(ecol_r) >= 32'(cfg.w_eff) - 32'd1) &&
                     (32'(erow_r) >= 32'(cfg.h_eff) - 32'd1);
  assign ec1 = 32'(ecol_r) + 32'd1;
  assign er1 = 32'(erow_r) + 32'd1;
  assign c1  = 32'(col_r) + 32'd1;
  assign r1  = 32'(row_r) + 32'd1;
  assign kp  = KW'(pend_r);
  assign kw  = KW'(cfg.w_eff);

  assign in_ready  = (state_r == F_IDLE);
  assign cmd_valid = (state_r == F_PUSH);

  always_comb begin
    cmd = cmd_r;
    cmd.smooth_ok = cmd_r.smooth_ok & mod_ok_r;
  end

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    ecol_nxt      = ecol_r;
    erow_nxt      = erow_r;
    pend_nxt      = pend_r;
    wr_nxt        = wr_r;
    step_nxt      = step_r;
    mod_ok_nxt    = mod_ok_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    push_pend_nxt = push_pend_r;
    cmd_nxt       = cmd_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          cmd_nxt.cslot     = back_slot(wr_r, kp);
          cmd_nxt.nb[0]     = back_slot(wr_r, kp + KW'(1));
          cmd_nxt.nb[1]     = back_slot(wr_r, kp - KW'(1));
          cmd_nxt.nb[2]     = back_slot(wr_r, kp + kw);
          cmd_nxt.nb[3]     = back_slot(wr_r, kp - kw);
          cmd_nxt.last      = last;
          cmd_nxt.wslot     = wr_r;
          cmd_nxt.e         = in_elevation;
          cmd_nxt.u         = in_vel_x;
          cmd_nxt.v         = in_vel_y;
          cmd_nxt.d         = in_depth;
          if (in_op) begin
            // Flush request drains the oldest pending cell without smoothing.
            if (pend_r != '0) begin
              cmd_nxt.emit      = 1'b1;
              cmd_nxt.write     = 1'b0;
              cmd_nxt.smooth_ok = 1'b0;
              pend_nxt          = pend_r - PEND_W'(1);
              state_nxt         = F_PUSH;
            end
          end else begin
            cmd_nxt.emit      = emit_full;
            cmd_nxt.write     = 1'b1;
            cmd_nxt.smooth_ok = emit_full & interior;
            if (!emit_full) begin
              pend_nxt = pend_r + PEND_W'(1);
            end
            wr_nxt = (32'(wr_r) == STORE_DEPTH - 1) ? '0 : wr_r + SLOT_W'(1);
            if (c1 >= 32'(cfg.w_eff)) begin
              col_nxt = '0;
              row_nxt = (r1 >= 32'(cfg.h_eff)) ? 16'd0 : r1[15:0];
            end else begin
              col_nxt = c1[W_W-1:0];
            end
            if (col_r == '0 && row_r == 16'd0) begin
              step_nxt      = in_frame_step;
              dvd_nxt       = in_frame_step;
              rem_nxt       = '0;
              dcnt_nxt      = '0;
              push_pend_nxt = 1'b1;
              state_nxt     = F_DIV;
            end else begin
              state_nxt = F_PUSH;
            end
          end
          if (state_nxt == F_PUSH || state_nxt == F_DIV) begin
            if (cmd_nxt.emit) begin
              if (ec1 >= 32'(cfg.w_eff)) begin
                ecol_nxt = '0;
                erow_nxt = (er1 >= 32'(cfg.h_eff)) ? 16'd0 : er1[15:0];
              end else begin
                ecol_nxt = ec1[W_W-1:0];
              end
            end
          end
        end else if (per_wr) begin
          dvd_nxt       = step_r;
          rem_nxt       = '0;
          dcnt_nxt      = '0;
          push_pend_nxt = 1'b0;
          state_nxt     = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[30:0], 1'b0};
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          mod_ok_nxt = (rem_step == 17'd0);
          state_nxt  = push_pend_r ? F_PUSH : F_IDLE;
        end
      end
      F_PUSH: begin
        if (cmd_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      ecol_r      <= '0;
      erow_r      <= '0;
      pend_r      <= '0;
      wr_r        <= '0;
      step_r      <= '0;
      mod_ok_r    <= 1'b1;
      dcnt_r      <= '0;
      push_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ecol_r      <= ecol_nxt;
      erow_r      <= erow_nxt;
      pend_r      <= pend_nxt;
      wr_r        <= wr_nxt;
      step_r      <= step_nxt;
      mod_ok_r    <= mod_ok_nxt;
      dcnt_r      <= dcnt_nxt;
      push_pend_r <= push_pend_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

// ----- sv/scns_cmdq.sv -----
// Two-entry command queue between the front end and the back end.
`default_nettype none
module scns_cmdq import scns_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic nonempty
);

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign dout     = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
    if (do_push) begin
      ent_r[wp_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ----- sv/scns_back.sv -----
// Back end: line store, neighbor fetch, ratio test, blend and result register.
`default_nettype none
`include "shallow_cell_neighbor_smoothing_macros.svh"
module scns_back import scns_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  output logic               q_pop,
  input  cmd_t               q_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_elevation,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic               out_was_smoothed,
  output logic               out_last_cell
);

  typedef enum logic [3:0] {
    B_IDLE, B_RD, B_RDW, B_EVAL, B_RCMP, B_NSUM, B_BA, B_BB, B_BC,
    B_BD0, B_BD, B_BE, B_CLAMP, B_OUT, B_WRITE
  } bstate_t;

  bstate_t            state_r, state_nxt;
  cmd_t               cmd_r;
  logic [127:0]       mem [STORE_DEPTH];
  logic [127:0]       mem_q;
  logic [SLOT_W-1:0]  rd_addr;
  logic [2:0]         ri_r, cap_idx_r;
  logic [1:0]         nb_idx;
  logic               cap_r;
  logic signed [31:0] ce_r, cu_r, cv_r, cd_r;
  logic signed [31:0] nbe_r [4];
  logic signed [31:0] nbu_r [4];
  logic signed [31:0] nbv_r [4];
  logic signed [31:0] nbd_r [4];
  logic signed [56:0] prod_r, p1_r, mul_out;
  logic [20:0]        mul_a;
  logic signed [34:0] mul_b;
  logic signed [52:0] num_r, p1c;
  logic signed [33:0] se_r, su_r, sv_r;
  logic [2:0]         cnt_r;
  logic [1:0]         vi_r;
  logic signed [31:0] res_r [3];
  logic [39:0]        dm_r, dm_step;
  logic [2:0]         drem_r, dr_step, sh3;
  logic               dneg_r;
  logic [2:0]         dcnt_r;
  logic               sm_r;
  logic               out_valid_r, out_sm_r, out_last_r;
  logic signed [31:0] out_e_r, out_u_r, out_v_r;

  logic               out_free, c_wet, ratio_hit;
  logic [3:0]         nwet;
  logic signed [33:0] se_c, su_c, sv_c;
  logic [2:0]         cnt_c;
  logic [31:0]        abs_c;
  logic [47:0]        lhs;
  logic signed [36:0] t37;
  logic signed [39:0] qval;
  logic signed [32:0] clamp_sum;

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == B_IDLE) && q_valid;
  assign c_wet     = is_wet(ce_r, cd_r, cfg.ground);
  assign abs_c     = ce_r[31] ? 32'(-ce_r) : 32'(ce_r);
  assign lhs       = {abs_c, 16'd0};
  assign ratio_hit = $signed({9'd0, lhs}) > prod_r;
  assign t37       = num_r[52:16];
  assign qval      = dneg_r ? -$signed(dm_r) : $signed(dm_r);
  assign clamp_sum = {cd_r[31], cd_r} + {res_r[0][31], res_r[0]};
  assign nb_idx    = 2'(cap_idx_r - 3'd1);

  assign mul_out = $signed({1'b0, mul_a}) * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      B_EVAL: begin
        mul_a = cfg.rb;
        mul_b = 35'(ce_r) + 35'(cd_r);
      end
      B_BA: begin
        mul_a = {4'd0, 17'h10000 - cfg.bc};
        mul_b = 35'(res_r[vi_r]);
      end
      B_BB: begin
        mul_a = {4'd0, cfg.bc};
        case (vi_r)
          2'd0:    mul_b = 35'(se_r);
          2'd1:    mul_b = 35'(su_r);
          default: mul_b = 35'(sv_r);
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    se_c  = '0;
    su_c  = '0;
    sv_c  = '0;
    cnt_c = '0;
    for (int i = 0; i < 4; i++) begin
      nwet[i] = is_wet(nbe_r[i], nbd_r[i], cfg.ground);
      if (nwet[i]) begin
        se_c  = se_c + 34'(nbe_r[i]);
        su_c  = su_c + 34'(nbu_r[i]);
        sv_c  = sv_c + 34'(nbv_r[i]);
        cnt_c = cnt_c + 3'd1;
      end
    end
  end

  always_comb begin
    case (cnt_r)
      3'd2:    p1c = 53'(p1_r) <<< 1;
      3'd3:    p1c = (53'(p1_r) <<< 1) + 53'(p1_r);
      3'd4:    p1c = 53'(p1_r) <<< 2;
      default: p1c = 53'(p1_r);
    endcase
  end

  // Eight restoring steps of the divide by the neighbor count.
  always_comb begin
    dm_step = dm_r;
    dr_step = drem_r;
    sh3     = '0;
    for (int i = 0; i < 8; i++) begin
      sh3 = {dr_step[1:0], dm_step[39]};
      if (sh3 >= cnt_r) begin
        dr_step = sh3 - cnt_r;
        dm_step = {dm_step[38:0], 1'b1};
      end else begin
        dr_step = sh3;
        dm_step = {dm_step[38:0], 1'b0};
      end
    end
  end

  always_comb begin
    case (ri_r)
      3'd0:    rd_addr = cmd_r.cslot;
      3'd1:    rd_addr = cmd_r.nb[0];
      3'd2:    rd_addr = cmd_r.nb[1];
      3'd3:    rd_addr = cmd_r.nb[2];
      default: rd_addr = cmd_r.nb[3];
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == B_WRITE) begin
      mem[cmd_r.wslot] <= {cmd_r.e, cmd_r.u, cmd_r.v, cmd_r.d};
    end
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (q_valid) state_nxt = q_cmd.emit ? B_RD : B_WRITE;
      B_RD:    if (ri_r == 3'd4 || !cmd_r.smooth_ok) state_nxt = B_RDW;
      B_RDW:   state_nxt = B_EVAL;
      B_EVAL:  state_nxt = (cmd_r.smooth_ok && c_wet) ? B_RCMP : B_OUT;
      B_RCMP:  state_nxt = ratio_hit ? B_NSUM : B_OUT;
      B_NSUM:  state_nxt = (cnt_c == 3'd0) ? B_OUT : B_BA;
      B_BA:    state_nxt = B_BB;
      B_BB:    state_nxt = B_BC;
      B_BC:    state_nxt = B_BD0;
      B_BD0:   state_nxt = B_BD;
      B_BD:    if (dcnt_r == 3'd4) state_nxt = B_BE;
      B_BE:    state_nxt = (vi_r == 2'd2) ? B_CLAMP : B_BA;
      B_CLAMP: state_nxt = B_OUT;
      B_OUT:   if (out_free) state_nxt = cmd_r.write ? B_WRITE : B_IDLE;
      B_WRITE: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= (state_r == B_RD);
      if (state_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    cap_idx_r <= ri_r;
    if (cap_r) begin
      if (cap_idx_r == 3'd0) begin
        {ce_r, cu_r, cv_r, cd_r} <= mem_q;
      end else begin
        {nbe_r[nb_idx], nbu_r[nb_idx], nbv_r[nb_idx], nbd_r[nb_idx]} <= mem_q;
      end
    end
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          cmd_r <= q_cmd;
        end
        ri_r <= 3'd0;
      end
      B_RD: ri_r <= ri_r + 3'd1;
      B_EVAL: begin
        prod_r   <= mul_out;
        res_r[0] <= ce_r;
        res_r[1] <= cu_r;
        res_r[2] <= cv_r;
        sm_r     <= 1'b0;
      end
      B_NSUM: begin
        se_r  <= se_c;
        su_r  <= su_c;
        sv_r  <= sv_c;
        cnt_r <= cnt_c;
        vi_r  <= 2'd0;
      end
      B_BA: prod_r <= mul_out;
      B_BB: begin
        p1_r   <= prod_r;
        prod_r <= mul_out;
      end
      B_BC: num_r <= p1c + 53'(prod_r) + (53'(cnt_r) <<< 15);
      B_BD0: begin
        // Floor division: a negative value divides its magnitude rounded up.
        dneg_r <= t37[36];
        dm_r   <= t37[36] ? 40'(-t37) + 40'(cnt_r - 3'd1) : 40'(t37);
        drem_r <= 3'd0;
        dcnt_r <= 3'd0;
      end
      B_BD: begin
        dm_r   <= dm_step;
        drem_r <= dr_step;
        dcnt_r <= dcnt_r + 3'd1;
      end
      B_BE: begin
        res_r[vi_r] <= sat32(qval);
        vi_r        <= vi_r + 2'd1;
      end
      B_CLAMP: begin
        sm_r <= 1'b1;
        if (clamp_sum < 33'sd0) begin
          res_r[0] <= sat32(HUNDREDTH_Q16 - 40'(cd_r));
          res_r[1] <= '0;
          res_r[2] <= '0;
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_e_r    <= res_r[0];
          out_u_r    <= res_r[1];
          out_v_r    <= res_r[2];
          out_sm_r   <= sm_r;
          out_last_r <= cmd_r.last;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_new_elevation = out_e_r;
  assign out_new_vel_x     = out_u_r;
  assign out_new_vel_y     = out_v_r;
  assign out_was_smoothed  = out_sm_r;
  assign out_last_cell     = out_last_r;

  `SCNS_ASSERT_NEXT(a_out_load, clk, rst_n, state_r == B_OUT && out_free, out_valid_r, "result not shown after load")
  `SCNS_ASSERT_ALWAYS(a_write_cmd, clk, rst_n, state_r != B_WRITE || cmd_r.write, "store write without a cell")
  `SCNS_ASSERT_ALWAYS(a_blend_smooth, clk, rst_n, state_r != B_BA || cmd_r.smooth_ok, "blend on a cell not cleared for smoothing")
  `SCNS_ASSERT_NEXT(a_no_sm_flush, clk, rst_n, state_r == B_OUT && out_free && !cmd_r.write, !out_sm_r, "flushed cell marked smoothed")

endmodule
`default_nettype wire

// ----- sv/shallow_cell_neighbor_smoothing.sv -----
// Top level of the shallow water cell neighbor smoothing block.
// Latency: a cell's result is emitted grid_width+1 cells after it, plus the back end time.
// Back end per request: a cell that emits nothing is only stored; a flush or border cell reads
// its own slot, an interior cell also its four neighbors, and a blend uses a shared multiplier.
// Front end: one request at a time; the first cell of a frame also runs a bit-serial step modulo period.
// Reset (synchronous, active low) clears counters and queues; the line store is not cleared.
`default_nettype none
module shallow_cell_neighbor_smoothing import scns_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [31:0]        in_frame_step,
  input  logic signed [31:0] in_elevation,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_depth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_elevation,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic               out_was_smoothed,
  output logic               out_last_cell,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers, written through the APB-style port.
  logic signed [31:0] ground_r;
  logic [20:0]        ratio_r;
  logic [16:0]        blend_r;
  logic [15:0]        period_r;
  logic [10:0]        width_r;
  logic [15:0]        height_r;
  logic               wr_en;
  logic [2:0]         reg_idx;
  cfg_t               cfg;

  // Command channel between front end, queue and back end.
  cmd_t               f_cmd, q_cmd;
  logic               f_valid, q_full, q_nonempty, q_pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_r <= '0;
      ratio_r  <= 21'd6554;
      blend_r  <= 17'd32768;
      period_r <= 16'd1;
      width_r  <= 11'd1024;
      height_r <= 16'd1024;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GROUND: ground_r <= pwdata;
        REG_RATIO:  ratio_r  <= pwdata[20:0];
        // Blend weights above one act as one.
        REG_BLEND:  blend_r  <= (pwdata[16:0] > 17'h10000) ? 17'h10000 : pwdata[16:0];
        REG_PERIOD: period_r <= pwdata[15:0];
        REG_WIDTH:  width_r  <= pwdata[10:0];
        REG_HEIGHT: height_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GROUND: prdata = ground_r;
      REG_RATIO:  prdata = 32'(ratio_r);
      REG_BLEND:  prdata = 32'(blend_r);
      REG_PERIOD: prdata = 32'(period_r);
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      default:    prdata = '0;
    endcase
  end

  // The grid is used with its width clamped to MAX_WIDTH (1024) and both
  // dimensions at least three, so that an interior always exists.
  always_comb begin
    cfg.ground = ground_r;
    cfg.rb     = ratio_r;
    cfg.bc     = blend_r;
    cfg.period = period_r;
    if (width_r < 11'd3) begin
      cfg.w_eff = W_W'(3);
    end else if (32'(width_r) > MAX_WIDTH) begin
      cfg.w_eff = W_W'(MAX_WIDTH);
    end else begin
      cfg.w_eff = W_W'(width_r);
    end
    cfg.h_eff = (height_r < 16'd3) ? 16'd3 : height_r;
  end

  // The front end tracks grid position and decides per request what the back
  // end must do; a period write reruns the frame step remainder.
  scns_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .per_wr        (wr_en && reg_idx == REG_PERIOD),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_frame_step (in_frame_step),
    .in_elevation  (in_elevation),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_depth      (in_depth),
    .cmd_valid     (f_valid),
    .cmd_ready     (!q_full),
    .cmd           (f_cmd)
  );

  scns_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_valid),
    .din      (f_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .dout     (q_cmd),
    .nonempty (q_nonempty)
  );

  // The back end owns the line store; commands run in order, so each emission
  // reads the store before the same request's cell is written.
  scns_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_valid           (q_nonempty),
    .q_pop             (q_pop),
    .q_cmd             (q_cmd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_new_elevation (out_new_elevation),
    .out_new_vel_x     (out_new_vel_x),
    .out_new_vel_y     (out_new_vel_y),
    .out_was_smoothed  (out_was_smoothed),
    .out_last_cell     (out_last_cell)
  );

endmodule
`default_nettype wire

// ----- sim/smoothing_checker.sv -----
// Checker for the smoothing block: watches every port but prdata, predicts each result and compares.
`timescale 1ns / 1ps
module smoothing_checker import scns_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_frame_step,
  input  logic [31:0] in_elevation,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_depth,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_new_elevation,
  input  logic [31:0] out_new_vel_x,
  input  logic [31:0] out_new_vel_y,
  input  logic        out_was_smoothed,
  input  logic        out_last_cell,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          cells_due
);

  typedef struct {
    logic [31:0] elev;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        smoothed;
    logic        last;
  } cell_result_t;

  cell_result_t due_cells[$];

  int          ground;
  int unsigned ratio, coeff, period, width_reg, height_reg;
  int          line_e[STORE_DEPTH];
  int          line_u[STORE_DEPTH];
  int          line_v[STORE_DEPTH];
  int          line_d[STORE_DEPTH];
  int unsigned wr_slot, col, row, pend, step_latch, emit_col, emit_row;

  function automatic int unsigned width_eff();
    if (width_reg < 3) begin
      return 3;
    end
    return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
  endfunction

  function automatic int unsigned height_eff();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic int unsigned slot_back(int unsigned k);
    return (wr_slot + STORE_DEPTH - (k % STORE_DEPTH)) % STORE_DEPTH;
  endfunction

  function automatic bit cell_wet(int unsigned s);
    return (line_d[s] >= ground) && ((longint'(line_e[s]) + longint'(line_d[s])) > 0);
  endfunction

  function automatic int clip32(longint x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return int'(x);
  endfunction

  // Weighted mix of a value with its neighbor sum; rounds half up.
  function automatic int mix(int x, longint sum, longint n);
    longint den, num, q;
    den = 64'sd65536 * n;
    num = longint'(65536 - coeff) * longint'(x) * n + longint'(coeff) * sum + den / 2;
    if (num >= 0) begin
      q = num / den;
    end else begin
      q = -((-num + den - 1) / den);
    end
    return clip32(q);
  endfunction

  // Produces the oldest pending cell; neighbors are only consulted when the window is full.
  function automatic cell_result_t oldest_cell(bit full);
    cell_result_t r;
    int unsigned w, h, c, per, nb;
    int          e, u, v, d;
    longint      tot, ae, se, su, sv, cnt;
    bit          inner;
    w = width_eff();
    h = height_eff();
    c = slot_back(pend);
    e = line_e[c];
    u = line_u[c];
    v = line_v[c];
    d = line_d[c];
    per = (period == 0) ? 1 : period;
    inner = emit_col >= 1 && emit_col <= w - 2 && emit_row >= 1 && emit_row <= h - 2;
    r.smoothed = 1'b0;
    r.last = (emit_col >= w - 1) && (emit_row >= h - 1);
    if (full && inner && (step_latch % per) == 0 && cell_wet(c)) begin
      tot = longint'(e) + longint'(d);
      ae = (e < 0) ? -longint'(e) : longint'(e);
      if ((ae <<< 16) > longint'(ratio) * tot) begin
        se = 0;
        su = 0;
        sv = 0;
        cnt = 0;
        for (int i = 0; i < 4; i++) begin
          case (i)
            0: nb = slot_back(pend + 1);
            1: nb = slot_back(pend - 1);
            2: nb = slot_back(pend + w);
            default: nb = slot_back(pend - w);
          endcase
          if (cell_wet(nb)) begin
            se += line_e[nb];
            su += line_u[nb];
            sv += line_v[nb];
            cnt++;
          end
        end
        if (cnt > 0) begin
          e = mix(e, se, cnt);
          u = mix(u, su, cnt);
          v = mix(v, sv, cnt);
          r.smoothed = 1'b1;
          // A blend that leaves the total depth negative is pinned just above dry.
          if (longint'(d) + longint'(e) < 0) begin
            e = clip32(-longint'(d) + 64'sd655);
            u = 0;
            v = 0;
          end
        end
      end
    end
    r.elev = e;
    r.vx = u;
    r.vy = v;
    emit_col++;
    if (emit_col >= w) begin
      emit_col = 0;
      emit_row++;
      if (emit_row >= h) begin
        emit_row = 0;
      end
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    cells_due = 0;
    foreach (line_e[i]) begin
      line_e[i] = 0;
      line_u[i] = 0;
      line_v[i] = 0;
      line_d[i] = 0;
    end
  end

  always @(posedge clk) begin
    cell_result_t got, want;
    int unsigned w;
    if (!rst_n) begin
      ground = 0;
      ratio = 6554;
      coeff = 32768;
      period = 1;
      width_reg = 1024;
      height_reg = 1024;
      wr_slot = 0;
      col = 0;
      row = 0;
      pend = 0;
      step_latch = 0;
      emit_col = 0;
      emit_row = 0;
      due_cells.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_GROUND: ground = pwdata;
          REG_RATIO:  ratio = pwdata[20:0];
          REG_BLEND:  coeff = (pwdata[16:0] > 65536) ? 65536 : pwdata[16:0];
          REG_PERIOD: period = pwdata[15:0];
          REG_WIDTH:  width_reg = pwdata[10:0];
          REG_HEIGHT: height_reg = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        w = width_eff();
        if (in_op) begin
          if (pend != 0) begin
            due_cells.push_back(oldest_cell(1'b0));
            pend--;
          end
        end else begin
          if (col == 0 && row == 0) begin
            step_latch = in_frame_step;
          end
          if (pend >= w + 1) begin
            due_cells.push_back(oldest_cell(1'b1));
          end else begin
            pend++;
          end
          line_e[wr_slot] = in_elevation;
          line_u[wr_slot] = in_vel_x;
          line_v[wr_slot] = in_vel_y;
          line_d[wr_slot] = in_depth;
          wr_slot = (wr_slot + 1) % STORE_DEPTH;
          col++;
          if (col >= w) begin
            col = 0;
            row++;
            if (row >= height_eff()) begin
              row = 0;
            end
          end
        end
      end
      if (out_valid && out_ready) begin
        got.elev = out_new_elevation;
        got.vx = out_new_vel_x;
        got.vy = out_new_vel_y;
        got.smoothed = out_was_smoothed;
        got.last = out_last_cell;
        if (due_cells.size() == 0) begin
          $error("unexpected result with new_elevation %0d", $signed(got.elev));
          fail_count++;
        end else begin
          want = due_cells.pop_front();
          if (got.elev !== want.elev) begin
            $error("new_elevation expected %0d actual %0d", $signed(want.elev),
                   $signed(got.elev));
            fail_count++;
          end
          if (got.vx !== want.vx) begin
            $error("new_vel_x expected %0d actual %0d", $signed(want.vx), $signed(got.vx));
            fail_count++;
          end
          if (got.vy !== want.vy) begin
            $error("new_vel_y expected %0d actual %0d", $signed(want.vy), $signed(got.vy));
            fail_count++;
          end
          if (got.smoothed !== want.smoothed) begin
            $error("was_smoothed expected %0b actual %0b", want.smoothed, got.smoothed);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last_cell expected %0b actual %0b", want.last, got.last);
            fail_count++;
          end
        end
      end
    end
    cells_due = due_cells.size();
  end

endmodule

// ----- sim/tb_shallow_cell_neighbor_smoothing.sv -----
// Testbench top for the smoothing block: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module tb_shallow_cell_neighbor_smoothing;
  import scns_pkg::*;

  localparam bit OP_CELL  = 1'b0;
  localparam bit OP_FLUSH = 1'b1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int INT_MAX = 32'sh7fffffff;
  localparam int INT_MIN = 32'sh80000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready, in_op;
  logic [31:0] in_frame_step, in_elevation, in_vel_x, in_vel_y, in_depth;
  logic        out_valid, out_ready;
  logic [31:0] out_new_elevation, out_new_vel_x, out_new_vel_y;
  logic        out_was_smoothed, out_last_cell;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, cells_due;

  // Tracked by the stimulus so that each phase knows how many flushes drain the window.
  int unsigned width_now;
  int unsigned period_now;
  int          requests_sent;
  int          cycles;

  shallow_cell_neighbor_smoothing i_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_op, .in_frame_step, .in_elevation, .in_vel_x, .in_vel_y,
    .in_depth,
    .out_valid, .out_ready, .out_new_elevation, .out_new_vel_x, .out_new_vel_y,
    .out_was_smoothed, .out_last_cell,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  smoothing_checker i_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_op, .in_frame_step, .in_elevation, .in_vel_x, .in_vel_y,
    .in_depth,
    .out_valid, .out_ready, .out_new_elevation, .out_new_vel_x, .out_new_vel_y,
    .out_was_smoothed, .out_last_cell,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .cells_due
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit, counted in clock cycles.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: a random stall before each result, with stretches of no stalls.
  // Once, the receiver holds off for a long stretch so that the block backs up into
  // its input while the sender keeps offering requests.
  initial begin : result_drain
    int gap, taken;
    bit steady;
    taken = 0;
    steady = 1'b0;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (taken % 64 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      gap = steady ? 0 : $urandom_range(0, 3);
      if (taken == 300) begin
        gap = 2500;
      end
      @(negedge clk);
      repeat (gap) begin
        out_ready = 1'b0;
        @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Register write over the configuration port: setup cycle, then access cycle.
  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (idx == REG_WIDTH) begin
      width_now = (value[10:0] < 3) ? 3 : ((value[10:0] > MAX_WIDTH) ? MAX_WIDTH : value[10:0]);
    end
    if (idx == REG_PERIOD) begin
      period_now = (value[15:0] == 0) ? 1 : value[15:0];
    end
  endtask

  // Offers one request; the sender waits a random gap first unless in a steady stretch.
  task automatic push_request(bit op, logic [31:0] step, logic [31:0] e, logic [31:0] u,
                              logic [31:0] v, logic [31:0] d);
    int gap;
    gap = ((requests_sent / 50) % 4 == 0) ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_op = op;
    in_frame_step = step;
    in_elevation = e;
    in_vel_x = u;
    in_vel_y = v;
    in_depth = d;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Mostly wet cells of moderate size so that the ratio test and the blend get exercised,
  // with some cells of fully random bits.
  task automatic push_random_cell(logic [31:0] step);
    int e, u, v, d;
    if ($urandom_range(0, 9) < 2) begin
      e = $urandom;
      u = $urandom;
      v = $urandom;
      d = $urandom;
    end else begin
      d = $urandom_range(0, 1 << 22);
      e = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      u = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      v = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'($urandom_range(0, 4095)) - 2048;
    end
    push_request(OP_CELL, step, e, u, v, d);
  endtask

  // Drains the window with flushes (one more than needed) and lets the block settle,
  // so that the registers may be rewritten.
  task automatic drain_window();
    repeat (width_now + 2) begin
      push_request(OP_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    @(negedge clk);
    in_valid = 1'b0;
    while (cells_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A 3 by 3 frame whose center is interior and whose edge midpoints are its neighbors.
  task automatic push_cross_frame(logic [31:0] step, int ce, int cd, int ne, int nu, int nv,
                                  int nd);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) begin
        push_request(OP_CELL, step, ce, 5, 7, cd);
      end else if (i % 2 == 1) begin
        push_request(OP_CELL, step, ne, nu, nv, nd);
      end else begin
        push_request(OP_CELL, step, 0, $urandom, $urandom, 65536);
      end
    end
  endtask

  initial begin : stimulus
    int extremes[5];
    int unsigned w_reg, h_reg, frames, random_cells;
    logic [31:0] step;
    extremes = '{INT_MIN, INT_MAX, 0, -1, 1};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_CELL;
    in_frame_step = '0;
    in_elevation = '0;
    in_vel_x = '0;
    in_vel_y = '0;
    in_depth = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    width_now = MAX_WIDTH;
    period_now = 1;
    requests_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Blend pulls the total depth negative: clamp to just above dry, velocities zeroed.
    // The frame starts at the grid origin, so the center's neighbors are its own cells.
    cfg_write(REG_WIDTH, 3);
    cfg_write(REG_HEIGHT, 3);
    cfg_write(REG_GROUND, 0);
    cfg_write(REG_RATIO, 0);
    cfg_write(REG_BLEND, 65536);
    cfg_write(REG_PERIOD, 1);
    push_cross_frame(0, -100, 200, -1000000, INT_MAX, INT_MIN, 2000000);
    drain_window();

    // No wet neighbor: the center passes through although it passes the ratio test.
    push_cross_frame(2, 300, 1000, 50, 1, 1, -5);
    drain_window();

    // Extreme settings and field values; period zero behaves as period one.
    cfg_write(REG_GROUND, 32'h80000000);
    cfg_write(REG_RATIO, 1048576);
    cfg_write(REG_BLEND, 0);
    cfg_write(REG_PERIOD, 0);
    for (int i = 0; i < 9; i++) begin
      push_request(OP_CELL, 32'hffffffff, extremes[i % 5], extremes[(i + 1) % 5],
                   extremes[(i + 2) % 5], extremes[(i + 3) % 5]);
    end
    drain_window();

    // Tallest grid and the highest ground level, on a frame that is left unfinished.
    cfg_write(REG_GROUND, 32'h7fffffff);
    cfg_write(REG_HEIGHT, 65535);
    cfg_write(REG_BLEND, 32768);
    for (int i = 0; i < 12; i++) begin
      push_random_cell($urandom);
    end
    drain_window();

    // Random phases: new settings each time, a few frames, an occasional stray flush.
    random_cells = 0;
    while (random_cells < 700) begin
      case ($urandom_range(0, 3))
        0: cfg_write(REG_GROUND, $urandom);
        1: cfg_write(REG_GROUND, int'($urandom_range(0, 1 << 17)) - (1 << 16));
        default: cfg_write(REG_GROUND, 0);
      endcase
      cfg_write(REG_RATIO, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65536)
                                                     : $urandom_range(0, 1048576));
      cfg_write(REG_BLEND, ($urandom_range(0, 7) == 0) ? $urandom_range(65536, 131071)
                                                     : $urandom_range(0, 65536));
      cfg_write(REG_PERIOD, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4));
      w_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      h_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
      cfg_write(REG_WIDTH, w_reg);
      cfg_write(REG_HEIGHT, h_reg);
      if (h_reg < 3) begin
        h_reg = 3;
      end
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        step = ($urandom_range(0, 3) != 0) ? period_now * $urandom_range(0, 50000) : $urandom;
        for (int i = 0; i < width_now * h_reg; i++) begin
          if ($urandom_range(0, 49) == 0) begin
            push_request(OP_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom);
          end
          push_random_cell((i == 0) ? step : $urandom);
          random_cells++;
        end
      end
      drain_window();
    end

    // Widest grid, with a width register beyond MAX_WIDTH: a full window of cells and
    // a short run of first-row results, so no neighbor is ever looked up. The cells are all dry.
    cfg_write(REG_GROUND, 32'h7fffffff);
    cfg_write(REG_RATIO, 6554);
    cfg_write(REG_BLEND, 32768);
    cfg_write(REG_PERIOD, 1);
    cfg_write(REG_HEIGHT, 3);
    cfg_write(REG_WIDTH, 2047);
    for (int i = 0; i < MAX_WIDTH + 64; i++) begin
      push_request(OP_CELL, 0, $urandom, $urandom, $urandom, $urandom_range(0, 1 << 22));
    end
    @(negedge clk);
    in_valid = 1'b0;
    while (cells_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
